// File: src/status_led_pattern_generator_defines.svh
// assertion macros shared by the status led pattern generator modules
`ifndef STATUS_LED_PATTERN_GENERATOR_DEFINES_SVH
`define STATUS_LED_PATTERN_GENERATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SLPG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SLPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/slpg_pkg.sv
// shared types and constants of the status led pattern generator
package slpg_pkg;

    // node status codes, six and seven are unknown
    typedef enum logic [2:0] {
        ST_BOOT       = 3'd0,
        ST_CONNECTING = 3'd1,
        ST_UNADOPTED  = 3'd2,
        ST_ADOPTING   = 3'd3,
        ST_ACTIVE     = 3'd4,
        ST_ERROR      = 3'd5
    } t_node_status;

    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;
    localparam int PIXEL_W  = 24;

    // fixed brightness levels
    localparam logic [7:0] BR_SOLID = 8'd64;
    localparam logic [7:0] BR_FLASH = 8'd128;
    localparam logic [7:0] BR_FLOOR = 8'd16;

    // reciprocals: floor(y/125) = (y*RECIP125)>>22 for y < 2^15,
    // floor(y/17) = (y*RECIP17)>>16 for y < 2^12
    localparam logic [15:0] RECIP125 = 16'd33555;
    localparam logic [11:0] RECIP17  = 12'd3856;

    // stage 1: folded residue of time/16 mod 125
    typedef struct packed {
        logic [12:0]  sum;
        logic [3:0]   t_lo;
        t_node_status st;
    } t_sum;

    // stage 2: time/16 mod 125
    typedef struct packed {
        logic [6:0]   m;
        logic [3:0]   t_lo;
        t_node_status st;
    } t_mod;

    // stage 3: distance from the ramp edge and led level
    typedef struct packed {
        logic [9:0]   ramp_pos;
        logic         led;
        t_node_status st;
    } t_phase;

    // stage 4: ramp numerator
    typedef struct packed {
        logic [17:0]  numer;
        logic         led;
        t_node_status st;
    } t_level;

    // stage 5: brightness
    typedef struct packed {
        logic [7:0]   br;
        logic         led;
        t_node_status st;
    } t_bright;

endpackage

// File: src/slpg_phase.sv
// time phase stages: modulo reduction, blink bits and ramp distance
`include "status_led_pattern_generator_defines.svh"
module slpg_phase
    import slpg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [TIME_W-1:0]   i_time_ms,
    input  logic [STATUS_W-1:0] i_node_status,
    output logic                o_valid,
    input  logic                i_ready,
    output t_phase              o_phase
);

    logic   r_v1, r_v2, r_v3;
    t_sum   r_s1, n_s1;
    t_mod   r_s2, n_s2;
    t_phase r_s3, n_s3;
    logic   adv1, adv2, adv3;
    logic   known;

    // stage advance, a stage moves when empty or when the next one moves
    assign adv3    = !r_v3 || i_ready;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;
    assign known   = (i_node_status <= 3'(ST_ERROR));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid && known;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) r_s1 <= n_s1;
        if (adv2 && r_v1)    r_s2 <= n_s2;
        if (adv3 && r_v2)    r_s3 <= n_s3;
    end

    // stage 1: fold time/16 in 7-bit chunks, 2^7, 2^14, 2^21 are 3, 9, 27 mod 125
    always_comb begin
        logic [27:0] x;
        x         = i_time_ms[31:4];
        n_s1.sum  = 13'(x[6:0]) + 13'(x[13:7]) * 13'd3
                  + 13'(x[20:14]) * 13'd9 + 13'(x[27:21]) * 13'd27;
        n_s1.t_lo = i_time_ms[3:0];
        n_s1.st   = t_node_status'(i_node_status);
    end

    // stage 2: second fold and final correction
    always_comb begin
        logic [7:0] f;
        f         = 8'(r_s1.sum[6:0]) + 8'(r_s1.sum[12:7]) * 8'd3;
        n_s2.m    = (f >= 8'd125) ? 7'(f - 8'd125) : f[6:0];
        n_s2.t_lo = r_s1.t_lo;
        n_s2.st   = r_s1.st;
    end

    // stage 3: phases within 2000, 1000, 500 and 200 ms
    always_comb begin
        logic [10:0] p2000;
        logic [9:0]  p1000;
        logic [8:0]  p500;
        logic        b500, b250, b100;
        logic [4:0]  r25;
        logic [5:0]  u2;
        logic [4:0]  u;

        p2000 = {r_s2.m, r_s2.t_lo};
        p1000 = (p2000 >= 11'd1000) ? 10'(p2000 - 11'd1000) : p2000[9:0];
        b500  = (p1000 >= 10'd500);
        p500  = b500 ? 9'(p1000 - 10'd500) : p1000[8:0];
        b250  = (p500 >= 9'd250);

        // time/8 mod 25 from the mod 125 residue and bit 3
        if (r_s2.m >= 7'd100)     r25 = 5'(r_s2.m - 7'd100);
        else if (r_s2.m >= 7'd75) r25 = 5'(r_s2.m - 7'd75);
        else if (r_s2.m >= 7'd50) r25 = 5'(r_s2.m - 7'd50);
        else if (r_s2.m >= 7'd25) r25 = 5'(r_s2.m - 7'd25);
        else                      r25 = r_s2.m[4:0];
        u2   = {r25, r_s2.t_lo[3]};
        u    = (u2 >= 6'd25) ? 5'(u2 - 6'd25) : u2[4:0];
        b100 = ({u, r_s2.t_lo[2:0]} >= 8'd100);

        // distance from the nearest ramp floor
        if (r_s2.st == ST_ERROR) begin
            n_s3.ramp_pos = (p2000 < 11'd1000) ? p2000[9:0] : 10'(11'd2000 - p2000);
        end else begin
            n_s3.ramp_pos = (p1000 < 10'd500) ? p1000 : 10'(10'd1000 - p1000);
        end

        case (r_s2.st)
            ST_CONNECTING, ST_UNADOPTED: n_s3.led = b250;
            ST_ADOPTING:                 n_s3.led = b100;
            ST_ERROR:                    n_s3.led = b500;
            default:                     n_s3.led = 1'b1;
        endcase
        n_s3.st = r_s2.st;
    end

    assign o_valid = r_v3;
    assign o_phase = r_s3;

    `SLPG_ASSERT_IMPLIES(a_mod_range, i_clk, i_rst_n, r_v2, r_s2.m < 7'd125, "residue out of range")
    `SLPG_ASSERT_IMPLIES(a_ramp_range, i_clk, i_rst_n, r_v3 && r_s3.st != ST_ERROR, r_s3.ramp_pos <= 10'd500, "ramp distance too large")

endmodule

// File: src/slpg_bright.sv
// brightness stages: ramp multiply and reciprocal divide
`include "status_led_pattern_generator_defines.svh"
module slpg_bright
    import slpg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_phase  i_phase,
    output logic    o_valid,
    input  logic    i_ready,
    output t_bright o_bright
);

    logic    r_v4, r_v5;
    t_level  r_s4, n_s4;
    t_bright r_s5, n_s5;
    logic    adv4, adv5;

    // stage advance
    assign adv5    = !r_v5 || i_ready;
    assign adv4    = !r_v4 || adv5;
    assign o_ready = adv4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (adv4) r_v4 <= i_valid;
            if (adv5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv4 && i_valid) r_s4 <= n_s4;
        if (adv5 && r_v4)    r_s5 <= n_s5;
    end

    // stage 4: distance times peak, 255 or 127 by shift and subtract
    always_comb begin
        if (i_phase.st == ST_ERROR) begin
            n_s4.numer = {i_phase.ramp_pos, 8'd0} - 18'(i_phase.ramp_pos);
        end else begin
            n_s4.numer = 18'({i_phase.ramp_pos, 7'd0}) - 18'(i_phase.ramp_pos);
        end
        n_s4.led = i_phase.led;
        n_s4.st  = i_phase.st;
    end

    // stage 5: divide by 1000 or 500 as shift then divide by 125
    always_comb begin
        logic [14:0] y;
        logic [30:0] prod;
        logic [7:0]  q;

        y    = (r_s4.st == ST_ERROR) ? r_s4.numer[17:3] : r_s4.numer[16:2];
        prod = 31'(y) * 31'(RECIP125);
        q    = prod[29:22];

        case (r_s4.st)
            ST_CONNECTING, ST_UNADOPTED: n_s5.br = q + BR_FLOOR;
            ST_ADOPTING:                 n_s5.br = BR_FLASH;
            ST_ERROR:                    n_s5.br = q;
            default:                     n_s5.br = BR_SOLID;
        endcase
        n_s5.led = r_s4.led;
        n_s5.st  = r_s4.st;
    end

    assign o_valid  = r_v5;
    assign o_bright = r_s5;

    `SLPG_ASSERT_IMPLIES(a_pulse_span, i_clk, i_rst_n, r_v5 && (r_s5.st == ST_CONNECTING || r_s5.st == ST_UNADOPTED), r_s5.br >= 8'd16 && r_s5.br <= 8'd143, "pulse brightness out of span")
    `SLPG_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, r_v5 && !i_ready, r_v5 && $stable(r_s5), "stalled brightness changed")

endmodule

// File: src/slpg_scale.sv
// channel scaling stage and output register
module slpg_scale
    import slpg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_bright            i_bright,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [PIXEL_W-1:0] o_pixel_grb,
    output logic               o_led_level
);

    logic               r_v;
    logic [PIXEL_W-1:0] r_pixel, n_pixel;
    logic               r_led;
    logic               adv;

    assign adv     = !r_v || i_ready;
    assign o_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (adv) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_pixel <= n_pixel;
            r_led   <= i_bright.led;
        end
    end

    // full channel gives br, channel 165 gives 165*br/255 = 11*br/17
    always_comb begin
        logic [11:0] y;
        logic [23:0] prod;
        logic [7:0]  full, part;

        full = i_bright.br;
        y    = {1'b0, full, 3'd0} + {3'd0, full, 1'b0} + {4'd0, full};
        prod = 24'(y) * 24'(RECIP17);
        part = prod[23:16];

        case (i_bright.st)
            ST_BOOT:       n_pixel = {8'd0, 8'd0, full};
            ST_CONNECTING: n_pixel = {full, full, 8'd0};
            ST_UNADOPTED:  n_pixel = {part, full, 8'd0};
            ST_ADOPTING:   n_pixel = i_bright.led ? {full, full, full} : '0;
            ST_ACTIVE:     n_pixel = {full, 8'd0, 8'd0};
            ST_ERROR:      n_pixel = {8'd0, full, 8'd0};
            default:       n_pixel = '0;
        endcase
    end

    assign o_valid     = r_v;
    assign o_pixel_grb = r_pixel;
    assign o_led_level = r_led;

endmodule

// File: src/status_led_pattern_generator.sv
// Status LED pattern generator.
// Input channel: i_valid / o_ready with i_time_ms (ms since boot, wrapping)
// and i_node_status (0 boot, 1 connecting, 2 unadopted, 3 adopting,
// 4 active, 5 error). Codes 6 and 7 are accepted and dropped: no result.
// Output channel: o_valid / i_ready with o_pixel_grb (green 23:16, red 15:8,
// blue 7:0) and o_led_level.
// Throughput: one transaction per cycle while the receiver holds i_ready high,
// set by six register stages (two modulo folds, phase, ramp multiply,
// divide, channel scale), each holding one item.
// Every stage stalls only when it holds an item and the next stage stalls,
// so while the receiver holds i_ready low the block keeps taking items until
// all six stages are full; nothing is lost or repeated.
// Reset (i_rst_n low at a clock edge) empties every stage; there is no other
// state and no startup pass.
module status_led_pattern_generator
    import slpg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [TIME_W-1:0]   i_time_ms,
    input  logic [STATUS_W-1:0] i_node_status,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [PIXEL_W-1:0]  o_pixel_grb,
    output logic                o_led_level
);

    logic    ph_valid, ph_ready;
    t_phase  ph_data;
    logic    br_valid, br_ready;
    t_bright br_data;

    // time phase and ramp distance
    slpg_phase u_phase (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_time_ms     (i_time_ms),
        .i_node_status (i_node_status),
        .o_valid       (ph_valid),
        .i_ready       (ph_ready),
        .o_phase       (ph_data)
    );

    // brightness
    slpg_bright u_bright (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (ph_valid),
        .o_ready  (ph_ready),
        .i_phase  (ph_data),
        .o_valid  (br_valid),
        .i_ready  (br_ready),
        .o_bright (br_data)
    );

    // color scaling and output register
    slpg_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (br_valid),
        .o_ready     (br_ready),
        .i_bright    (br_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pixel_grb (o_pixel_grb),
        .o_led_level (o_led_level)
    );

endmodule
